[rtl/leb_pkg.sv]
package leb_pkg;

    // Largest line the block is built for.
    localparam int MAX_CHARS_DEFAULT = 256;

    // Field widths of the channels and the configuration port.
    localparam int OPCODE_W = 3;
    localparam int KEY_W    = 16;
    localparam int COL_W    = 8;
    localparam int IDX_W    = 8;
    localparam int CHAR_W   = 8;
    localparam int TLEN_W   = 9;
    localparam int POS_W    = 9;
    localparam int EVENT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 40;

    // Operations carried in the opcode field.
    localparam logic [OPCODE_W-1:0] OP_KEY     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CLICK   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_OUTSIDE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SETLEN  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_READ    = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SNAP    = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SWAP    = 3'd7;

    // Control bytes with a meaning of their own.
    localparam logic [CHAR_W-1:0] KEY_EXT = 8'h00;
    localparam logic [CHAR_W-1:0] KEY_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] KEY_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] KEY_RET = 8'h0d;
    localparam logic [CHAR_W-1:0] KEY_ESC = 8'h1b;
    localparam logic [CHAR_W-1:0] KEY_DEL = 8'h7f;

    // Event codes of the result word.
    localparam logic [EVENT_W-1:0] EV_EDIT    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_RETURN  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_TAB     = 2'd2;
    localparam logic [EVENT_W-1:0] EV_OUTSIDE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd5;

    // Configuration reset values.
    localparam logic [POS_W-1:0] CAPACITY_RST = 9'd256;
    localparam logic [POS_W-1:0] WINDOW_RST   = 9'd32;
    localparam logic [KEY_W-1:0] LEFT_RST     = 16'd19200;
    localparam logic [KEY_W-1:0] RIGHT_RST    = 16'd19712;
    localparam logic [KEY_W-1:0] HOME_RST     = 16'd18432;
    localparam logic [KEY_W-1:0] END_RST      = 16'd20480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_POKE,
        ST_READ,
        ST_DONE
    } leb_state_t;

    // What the memory sweep does with each word it reads.
    typedef enum logic [2:0] {
        SH_NONE,
        SH_INSERT,
        SH_REMOVE,
        SH_COPY,
        SH_SWAP
    } shift_mode_t;

endpackage

[rtl/leb_ram.sv]
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/line_edit_buffer_with_scroll.sv]
// Channel  Direction  Word bits (lowest first)
// s_       in         tuser: opcode[2:0]; tdata: key_code, column, char_index,
//                     char_value, text_length, zero fill to 56 bits
// m_       out        tdata: cursor_pos, view_start, line_length, event_res,
//                     read_value, zero fill to 40 bits
// cfg_     in         write enable, register index, 16-bit write data
//
// Sequence: every item passes execute and done; read char adds a memory read
// state, insert and remove add a sweep over the moved characters and a final
// write of the cleared or inserted character, and snapshot and undo swap add
// a sweep over the whole store. A sweep moves one character a cycle through
// the single read and write port of each character memory.
// Reset clears the cursor, view and lengths and loads the configuration
// defaults; the character memories stay undefined until written.
// The input is ready only while the sequencer is idle; a result held by a
// stalled output still lets the next word in and is followed by it.
module line_edit_buffer_with_scroll
    import leb_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key_code[15:0], column[23:16], char_index[31:24], char_value[39:32],
    // text_length[48:40], zeros above.
    input  logic [S_DATA_W-1:0]   s_tdata,
    // opcode[2:0].
    input  logic [OPCODE_W-1:0]   s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cursor_pos[8:0], view_start[17:9], line_length[26:18], event_res[28:27],
    // read_value[36:29], zeros above.
    output logic [M_DATA_W-1:0]   m_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Address width of the stores, width of a position that may equal
    // MAX_CHARS, and a working width that holds any sum of two positions.
    localparam int AW = $clog2(MAX_CHARS);
    localparam int LW = $clog2(MAX_CHARS + 1);
    localparam int VW = ((LW > POS_W) ? LW : POS_W) + 1;

    // Configuration registers.
    logic [POS_W-1:0] capacity_reg;
    logic [POS_W-1:0] window_reg;
    logic [KEY_W-1:0] left_reg;
    logic [KEY_W-1:0] right_reg;
    logic [KEY_W-1:0] home_reg;
    logic [KEY_W-1:0] end_reg;

    // Captured input word.
    logic [OPCODE_W-1:0] op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [COL_W-1:0]    col_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CHAR_W-1:0]   val_reg;
    logic [TLEN_W-1:0]   tlen_reg;

    // Editor state.
    leb_state_t state_reg, state_next;
    logic [LW-1:0] cursor_reg, cursor_next;
    logic [LW-1:0] view_reg, view_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] ulen_reg, ulen_next;
    logic [EVENT_W-1:0] ev_reg, ev_next;
    logic [CHAR_W-1:0]  rd_reg, rd_next;

    // Sweep sequencer: mode, reads left, read pointer, and the address of
    // the word that is in flight through the memory read register.
    shift_mode_t mode_reg, mode_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     pa_reg, pa_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     poke_addr_reg, poke_addr_next;
    logic [CHAR_W-1:0] poke_data_reg, poke_data_next;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                load_out;

    // Memory ports.
    logic              text_we, undo_we;
    logic [AW-1:0]     text_waddr, undo_waddr, text_raddr;
    logic [CHAR_W-1:0] text_wdata, undo_wdata, text_rdata, undo_rdata;

    // Working-width views of state and settings.
    logic [VW-1:0] len_v, cur_v, vf_v, ulen_v, w_v, cap_v, c0, max_v, idx_v;
    logic          idx_ok;

    assign max_v  = VW'(MAX_CHARS);
    assign len_v  = VW'(len_reg);
    assign cur_v  = VW'(cursor_reg);
    assign vf_v   = VW'(view_reg);
    assign ulen_v = VW'(ulen_reg);
    // A zero window width behaves as one cell.
    assign w_v    = (window_reg == '0) ? VW'(1) : VW'(window_reg);
    assign cap_v  = (VW'(capacity_reg) < max_v) ? VW'(capacity_reg) : max_v;
    // Keys always see the cursor clamped to the line length.
    assign c0     = (cur_v > len_v) ? len_v : cur_v;
    assign idx_v  = VW'(idx_reg);
    assign idx_ok = idx_v < max_v;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    leb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_text_ram (
        .clk   (aclk),
        .we    (text_we),
        .waddr (text_waddr),
        .wdata (text_wdata),
        .raddr (text_raddr),
        .rdata (text_rdata)
    );

    leb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_undo_ram (
        .clk   (aclk),
        .we    (undo_we),
        .waddr (undo_waddr),
        .wdata (undo_wdata),
        .raddr (ptr_reg),
        .rdata (undo_rdata)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RST;
            window_reg   <= WINDOW_RST;
            left_reg     <= LEFT_RST;
            right_reg    <= RIGHT_RST;
            home_reg     <= HOME_RST;
            end_reg      <= END_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CAPACITY: capacity_reg <= cfg_data[POS_W-1:0];
                CFG_WINDOW:   window_reg   <= cfg_data[POS_W-1:0];
                CFG_LEFT:     left_reg     <= cfg_data;
                CFG_RIGHT:    right_reg    <= cfg_data;
                CFG_HOME:     home_reg     <= cfg_data;
                CFG_END:      end_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[15:0];
            col_reg  <= s_tdata[23:16];
            idx_reg  <= s_tdata[31:24];
            val_reg  <= s_tdata[39:32];
            tlen_reg <= s_tdata[48:40];
        end
    end

    // Editing arithmetic and sweep bookkeeping. All cursor, view and length
    // updates land at the end of the execute cycle; the sweep that follows
    // only moves characters.
    always_comb begin
        logic [VW-1:0] nc, nv, nl, p, span;

        nc = cur_v;
        nv = vf_v;
        nl = len_v;
        p  = '0;
        span = '0;
        ulen_next      = ulen_reg;
        ev_next        = ev_reg;
        rd_next        = rd_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        pa_next        = pa_reg;
        pend_next      = 1'b0;
        poke_addr_next = poke_addr_reg;
        poke_data_next = poke_data_reg;

        case (state_reg)
            ST_EXEC: begin
                ev_next   = EV_EDIT;
                rd_next   = '0;
                mode_next = SH_NONE;
                cnt_next  = '0;
                case (op_reg)
                    OP_KEY: begin
                        nc = c0;
                        if (key_reg[7:0] == KEY_EXT) begin
                            // Extended key: the first matching code wins.
                            if (key_reg == left_reg) begin
                                if (c0 != '0) begin
                                    nc = c0 - VW'(1);
                                    if (nc < vf_v) begin
                                        nv = vf_v - VW'(1);
                                    end
                                end
                            end else if (key_reg == right_reg) begin
                                if (c0 < len_v) begin
                                    nc = c0 + VW'(1);
                                    if (nc >= vf_v && nc - vf_v >= w_v) begin
                                        nv = vf_v + VW'(1);
                                    end
                                end
                            end else if (key_reg == home_reg) begin
                                nc = '0;
                                nv = '0;
                            end else if (key_reg == end_reg) begin
                                nc = len_v;
                                if (len_v >= w_v) begin
                                    nv = len_v - w_v + VW'(1);
                                end
                            end
                        end else begin
                            case (key_reg[7:0])
                                KEY_TAB: ev_next = EV_TAB;
                                KEY_RET: ev_next = EV_RETURN;
                                KEY_ESC: begin
                                    nl = '0;
                                    nc = '0;
                                    nv = '0;
                                end
                                KEY_DEL, KEY_BS: begin
                                    if (key_reg[7:0] == KEY_DEL) begin
                                        p = (c0 >= len_v) ? len_v - VW'(1) : c0;
                                    end else begin
                                        p = c0 - VW'(1);
                                    end
                                    if (len_v != '0 &&
                                        (key_reg[7:0] == KEY_DEL || c0 != '0)) begin
                                        // Pull the tail left over position p and
                                        // clear the freed last cell.
                                        nc = p;
                                        nl = len_v - VW'(1);
                                        if (p < vf_v) begin
                                            nv = vf_v - VW'(1);
                                        end
                                        span           = len_v - VW'(1) - p;
                                        mode_next      = SH_REMOVE;
                                        cnt_next       = span[LW-1:0];
                                        ptr_next       = AW'(p + VW'(1));
                                        poke_addr_next = AW'(len_v - VW'(1));
                                        poke_data_next = '0;
                                    end
                                end
                                default: begin
                                    if (len_v < cap_v) begin
                                        // Push the tail right from the end, then
                                        // drop the new character in at the cursor.
                                        span           = len_v - c0;
                                        mode_next      = SH_INSERT;
                                        cnt_next       = span[LW-1:0];
                                        ptr_next       = AW'(len_v - VW'(1));
                                        poke_addr_next = AW'(c0);
                                        poke_data_next = key_reg[7:0];
                                        nc = c0 + VW'(1);
                                        nl = len_v + VW'(1);
                                        if (nc >= vf_v && nc - vf_v >= w_v) begin
                                            nv = vf_v + VW'(1);
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    OP_CLICK: begin
                        nc = vf_v + VW'(col_reg);
                        if (nc >= vf_v + w_v) begin
                            nc = vf_v + w_v - VW'(1);
                        end
                        if (nc > len_v) begin
                            nc = len_v;
                        end
                    end
                    OP_OUTSIDE: ev_next = EV_OUTSIDE;
                    OP_SETLEN: begin
                        nl = (VW'(tlen_reg) < max_v) ? VW'(tlen_reg) : max_v;
                        nc = (nl >= w_v) ? w_v - VW'(1) : nl;
                        nv = '0;
                    end
                    OP_SNAP: begin
                        ulen_next = len_reg;
                        mode_next = SH_COPY;
                        cnt_next  = LW'(MAX_CHARS);
                        ptr_next  = '0;
                    end
                    OP_SWAP: begin
                        nl = ulen_v;
                        ulen_next = len_reg;
                        nc = (nl >= w_v) ? w_v - VW'(1) : nl;
                        nv = '0;
                        mode_next = SH_SWAP;
                        cnt_next  = LW'(MAX_CHARS);
                        ptr_next  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHIFT: begin
                if (cnt_reg != '0) begin
                    cnt_next  = cnt_reg - LW'(1);
                    ptr_next  = (mode_reg == SH_INSERT) ? ptr_reg - AW'(1)
                                                        : ptr_reg + AW'(1);
                    pa_next   = ptr_reg;
                    pend_next = 1'b1;
                end
            end
            ST_READ: begin
                rd_next = idx_ok ? text_rdata : '0;
            end
            default: begin
            end
        endcase

        cursor_next = nc[LW-1:0];
        view_next   = nv[LW-1:0];
        len_next    = nl[LW-1:0];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (mode_next != SH_NONE) begin
                    state_next = ST_SHIFT;
                end else if (op_reg == OP_READ) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (cnt_reg == '0) begin
                    if (mode_reg == SH_INSERT || mode_reg == SH_REMOVE) begin
                        state_next = ST_POKE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_POKE: state_next = ST_DONE;
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory strobes and result register loading.
    always_comb begin
        text_we    = 1'b0;
        text_waddr = pa_reg;
        text_wdata = text_rdata;
        undo_we    = 1'b0;
        undo_waddr = pa_reg;
        undo_wdata = text_rdata;
        // Outside a sweep the text memory reads the requested index, so the
        // word is ready in the cycle after execute.
        text_raddr = (state_reg == ST_SHIFT) ? ptr_reg : idx_v[AW-1:0];

        case (state_reg)
            ST_EXEC: begin
                if (op_reg == OP_WRITE && idx_ok) begin
                    text_we    = 1'b1;
                    text_waddr = idx_v[AW-1:0];
                    text_wdata = val_reg;
                end
            end
            ST_SHIFT: begin
                if (pend_reg) begin
                    case (mode_reg)
                        SH_INSERT: begin
                            text_we    = 1'b1;
                            text_waddr = pa_reg + AW'(1);
                        end
                        SH_REMOVE: begin
                            text_we    = 1'b1;
                            text_waddr = pa_reg - AW'(1);
                        end
                        SH_COPY: begin
                            undo_we = 1'b1;
                        end
                        SH_SWAP: begin
                            text_we    = 1'b1;
                            text_wdata = undo_rdata;
                            undo_we    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POKE: begin
                text_we    = 1'b1;
                text_waddr = poke_addr_reg;
                text_wdata = poke_data_reg;
            end
            default: begin
            end
        endcase

        load_out    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
        m_data_next = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, rd_reg, ev_reg,
                            POS_W'(VW'(len_reg)), POS_W'(VW'(view_reg)),
                            POS_W'(VW'(cursor_reg))};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            view_reg    <= '0;
            len_reg     <= '0;
            ulen_reg    <= '0;
            mode_reg    <= SH_NONE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            view_reg    <= view_next;
            len_reg     <= len_next;
            ulen_reg    <= ulen_next;
            mode_reg    <= mode_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg        <= ev_next;
        rd_reg        <= rd_next;
        ptr_reg       <= ptr_next;
        pa_reg        <= pa_next;
        poke_addr_reg <= poke_addr_next;
        poke_data_reg <= poke_data_next;
        m_data_reg    <= m_data_next;
    end

    // The window never starts past the cursor, and the cursor never passes
    // the end of the line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        view_reg <= cursor_reg && cursor_reg <= len_reg)
        else $error("cursor or view outside the line");

    assert property (@(posedge aclk) disable iff (!aresetn)
        VW'(len_reg) <= max_v && VW'(ulen_reg) <= max_v)
        else $error("line length beyond the store");

    // A new result only comes out of the done state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

    // The memories are only written while an item is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (text_we || undo_we) |-> !s_tready)
        else $error("memory write while idle");

    // The sweep leaves only after its last read has been written back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && state_next != ST_SHIFT) |-> cnt_reg == '0)
        else $error("sweep left with reads outstanding");

endmodule
